/* hdl/move_to_front_list_unit_defines.svh */
// ----------------------------------------------------------------------------
// Move-to-front list unit: assertion macros
// Concurrent assertion wrappers that compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef MOVE_TO_FRONT_LIST_UNIT_DEFINES_SVH
`define MOVE_TO_FRONT_LIST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define MTF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtf assertion failed");

// Next-cycle implication, disabled during reset.
`define MTF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtf assertion failed");

`else

`define MTF_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define MTF_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* hdl/mtf_pkg.sv */
// ----------------------------------------------------------------------------
// Move-to-front list unit package
// Widths, status codes and controller/datapath bundle types.
// ----------------------------------------------------------------------------
package mtf_pkg;

  localparam int MTF_DEPTH = 16;
  localparam int WORD_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 4;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_FIND   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } mtf_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } mtf_stat_t;

endpackage

/* hdl/mtf_cmd_if.sv */
// ----------------------------------------------------------------------------
// Move-to-front list unit: command channel
// Valid/ready channel carrying one append or find command.
// ----------------------------------------------------------------------------
interface mtf_cmd_if import mtf_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

/* hdl/mtf_res_if.sv */
// ----------------------------------------------------------------------------
// Move-to-front list unit: result channel
// Valid/ready channel carrying one status and position per command.
// ----------------------------------------------------------------------------
interface mtf_res_if import mtf_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;

  modport source (output valid, output status, output position, input ready);
  modport sink   (input valid, input status, input position, output ready);
endinterface

/* hdl/mtf_controller.sv */
// ----------------------------------------------------------------------------
// Move-to-front list unit: controller
// Two-state sequencer that captures a command and then fires the update.
// ----------------------------------------------------------------------------
`include "move_to_front_list_unit_defines.svh"

module mtf_controller import mtf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  mtf_stat_t stat,
  output mtf_ctrl_t ctrl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  assign in_ready  = (state == S_IDLE);
  assign ctrl.load = in_valid && in_ready;
  // The update waits while the previous result still sits unclaimed.
  assign ctrl.exec = (state == S_EXEC) && !stat.out_busy;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (ctrl.load) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (ctrl.exec) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `MTF_ASSERT_NEXT(a_exec_returns_idle, clk, rst, ctrl.exec, state == S_IDLE)

endmodule

/* hdl/mtf_datapath.sv */
// ----------------------------------------------------------------------------
// Move-to-front list unit: datapath
// Entry row with parallel compare, priority select, shift and result register.
// ----------------------------------------------------------------------------
`include "move_to_front_list_unit_defines.svh"

module mtf_datapath import mtf_pkg::*; #(
  parameter int DEPTH = MTF_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mtf_ctrl_t                ctrl,
  output mtf_stat_t                stat,
  input  logic                     in_command,
  input  logic signed [WORD_W-1:0] in_value,
  input  logic                     res_ready,
  output logic                     res_valid,
  output logic [STATUS_W-1:0]      res_status,
  output logic [POS_W-1:0]         res_position
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic              command_q;
  logic [WORD_W-1:0] value_q;
  logic [WORD_W-1:0] entries [DEPTH];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  logic [DEPTH-1:0]    match;
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;
  logic                full;
  logic [STATUS_W-1:0] status_next;
  logic [POS_W-1:0]    position_next;

  assign full          = (count == CNT_W'(DEPTH));
  assign stat.out_busy = res_valid && !res_ready;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      command_q <= in_command;
      value_q   <= in_value;
    end
  end

  // Every live entry is compared against the key at once.
  for (genvar i = 0; i < DEPTH; i++) begin : g_match
    assign match[i] = (CNT_W'(i) < count) && (entries[i] == value_q);
  end

  // The entry nearest the head wins.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // On a find hit, entries up to the match shift back one place and the key
  // lands at the head; an append writes only the slot at the fill count.
  for (genvar k = 0; k < DEPTH; k++) begin : g_entry
    if (k == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (ctrl.exec) begin
          if (command_q == CMD_FIND) begin
            if (hit) entries[k] <= value_q;
          end else if (!full && count[IDX_W-1:0] == IDX_W'(k)) begin
            entries[k] <= value_q;
          end
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (ctrl.exec) begin
          if (command_q == CMD_FIND) begin
            if (hit && IDX_W'(k) <= hit_idx) entries[k] <= entries[k-1];
          end else if (!full && count[IDX_W-1:0] == IDX_W'(k)) begin
            entries[k] <= value_q;
          end
        end
      end
    end
  end

  always_comb begin
    status_next   = ST_DONE;
    position_next = '0;
    count_next    = count;
    if (command_q == CMD_APPEND) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        position_next = POS_W'(count);
        count_next    = count + CNT_W'(1);
      end
    end else if (hit) begin
      position_next = POS_W'(hit_idx);
    end else begin
      status_next = ST_NOTFOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (ctrl.exec) begin
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      res_status   <= status_next;
      res_position <= position_next;
    end
  end

  `MTF_ASSERT_IMPL(a_count_in_range, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `MTF_ASSERT_NEXT(a_find_to_head, clk, rst, ctrl.exec && command_q == CMD_FIND && hit, entries[0] == $past(value_q))
  `MTF_ASSERT_NEXT(a_append_grows, clk, rst, ctrl.exec && command_q == CMD_APPEND && !full, count == $past(count) + CNT_W'(1))

endmodule

/* hdl/move_to_front_list_unit.sv */
// ----------------------------------------------------------------------------
// Move-to-front list unit
// Self-organizing list of up to DEPTH words with append and find-to-front.
// ----------------------------------------------------------------------------
// Each accepted command produces exactly one result. A command is captured
// when taken and executed from the EXEC state; no new command is taken
// until then, as the compare-select-shift step over the whole entry row
// needs the order left by the previous command. The result sits in an
// output register, and a command may be accepted while it waits; execution
// of that command holds until the result is taken. Position reports the
// low four bits of the entry position.
// ----------------------------------------------------------------------------
module move_to_front_list_unit import mtf_pkg::*; #(
  parameter int DEPTH = MTF_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  mtf_cmd_if.sink   cmd,
  mtf_res_if.source res
);

  mtf_ctrl_t ctrl;
  mtf_stat_t stat;

  mtf_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  mtf_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .in_command   (cmd.command),
    .in_value     (cmd.value),
    .res_ready    (res.ready),
    .res_valid    (res.valid),
    .res_status   (res.status),
    .res_position (res.position)
  );

endmodule

/* bench/tb_move_to_front_list_unit.sv */
// ----------------------------------------------------------------------------
// Testbench for the move-to-front list unit
// Drives append and find commands with random gaps, stalls the result
// channel at random, and checks every status and position against a
// behavioral copy of the list that is kept in step with accepted commands.
// ----------------------------------------------------------------------------
module tb_move_to_front_list_unit import mtf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 500;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 200;
  localparam int MAX_GAP = 17;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
  } mtf_result_t;

  // Keeps its own copy of the list and the results it must lead to.
  class mtf_list_tracker;
    logic [WORD_W-1:0] words[MTF_DEPTH];
    int                count;
    mtf_result_t       awaited_results[$];
    int                errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function void take_command(logic cmd, logic [WORD_W-1:0] word);
      mtf_result_t r;
      int          hit;
      r.status   = ST_DONE;
      r.position = '0;
      hit        = -1;
      if (cmd == CMD_APPEND) begin
        if (count < MTF_DEPTH) begin
          words[count] = word;
          r.position   = POS_W'(count);
          count++;
        end else begin
          r.status = ST_FULL;
        end
      end else begin
        for (int i = 0; i < count; i++) begin
          if (hit < 0 && words[i] == word) hit = i;
        end
        if (hit >= 0) begin
          r.position = POS_W'(hit);
          for (int k = hit; k > 0; k--) words[k] = words[k-1];
          words[0] = word;
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      awaited_results.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [POS_W-1:0] position);
      mtf_result_t exp_r;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d position=%0d", $time, status, position);
        errors++;
        return;
      end
      exp_r = awaited_results.pop_front();
      if (status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
        errors++;
      end
      if (position !== exp_r.position) begin
        $display("%0t: position expected %0d actual %0d", $time, exp_r.position, position);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  mtf_cmd_if cmd_ch ();
  mtf_res_if res_ch ();

  mtf_list_tracker tracker = new();

  int  idle_cycles = 0;
  bit  cmd_steady = 1'b0;
  bit  res_steady = 1'b0;

  always #4 clk = ~clk;

  move_to_front_list_unit u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // Draws the wait before the next transfer; now and then a side switches
  // between random gaps and back-to-back operation.
  function automatic int draw_gap(ref bit steady);
    if ($urandom_range(0, 31) == 0) steady = ~steady;
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic send_command(logic cmd, logic [WORD_W-1:0] word);
    int gap;
    gap = draw_gap(cmd_steady);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= cmd;
    cmd_ch.value   <= word;
    do @(posedge clk); while (!cmd_ch.ready);
    tracker.take_command(cmd, word);
  endtask

  // Result side: random stalls, each transfer checked on the edge it happens.
  initial begin
    int gap;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = draw_gap(res_steady);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      tracker.check_result(res_ch.status, res_ch.position);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int               pick;
    logic [WORD_W-1:0] word;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.command <= CMD_APPEND;
    cmd_ch.value   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty list, field extremes, duplicates, full list.
    send_command(CMD_FIND, 32'h0000_0000);
    send_command(CMD_APPEND, 32'h8000_0000);
    send_command(CMD_APPEND, 32'h7FFF_FFFF);
    send_command(CMD_APPEND, 32'h0000_0000);
    send_command(CMD_APPEND, 32'hFFFF_FFFF);
    send_command(CMD_APPEND, 32'h0000_0005);
    send_command(CMD_APPEND, 32'h0000_0005);
    send_command(CMD_FIND, 32'h0000_0005);
    send_command(CMD_FIND, 32'hFFFF_FFFF);
    send_command(CMD_FIND, 32'h0000_1234);
    for (int i = 0; i < 9; i++) send_command(CMD_APPEND, 32'h1000_0000 + i);
    send_command(CMD_APPEND, 32'h5555_5555);
    send_command(CMD_APPEND, 32'hAAAA_AAAA);
    send_command(CMD_FIND, 32'h5555_5555);
    send_command(CMD_FIND, 32'h5555_5555);

    // Random part: mostly finds of words in the list, the rest absent
    // words, near-miss small values and appends against the full list.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        word = tracker.words[$urandom_range(0, tracker.count - 1)];
        send_command(CMD_FIND, word);
      end else if (pick < 80) begin
        word = $urandom();
        send_command(CMD_FIND, word);
      end else if (pick < 88) begin
        word = $urandom_range(0, 7);
        send_command(CMD_FIND, word);
      end else begin
        word = $urandom();
        send_command(CMD_APPEND, word);
      end
    end
    cmd_ch.valid <= 1'b0;

    while (tracker.awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
